### rtl/core/tlc_pkg.sv
// Shared types and codes of the tripwire line crossing counter.
`timescale 1ns / 1ps

package tlc_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CROSS,
        ST_EMIT,
        ST_SWEEP,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    localparam logic [1:0] ACT_DETECT = 2'd0;
    localparam logic [1:0] ACT_EOF    = 2'd1;
    localparam logic [1:0] ACT_RESET  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] FILT_BOTH   = 2'd0;
    localparam logic [1:0] FILT_A_TO_B = 2'd1;
    localparam logic [1:0] FILT_B_TO_A = 2'd2;
    localparam logic [1:0] FILT_NONE   = 2'd3;

    localparam logic [2:0] REG_LINE0  = 3'd0;
    localparam logic [2:0] REG_LINE1  = 3'd1;
    localparam logic [2:0] REG_LINE2  = 3'd2;
    localparam logic [2:0] REG_LINE3  = 3'd3;
    localparam logic [2:0] REG_MODES  = 3'd4;
    localparam logic [2:0] REG_ENABLE = 3'd5;

    localparam int GEOM_SLOTS = 4;
    localparam int MODES_W    = 12;

endpackage

### rtl/core/tripwire_line_crossing_counter.sv
// Top level of the tripwire line crossing counter: register port, sequencer, counts.
`timescale 1ns / 1ps

// Tripwire line crossing counter. Each input beat carries one action: a
// detection of a tracked object, an end of frame, a reset of the counts, or a
// read of the counts. Track history (known and seen flags plus the last foot
// point, the box bottom centre at one extra fractional bit) lives in one
// single-port-read memory of NUM_TRACKS words. After reset the block clears
// that memory, one word a cycle, before it takes its first beat; register
// writes are taken during that time. A detection of a known track does one
// memory read, then each line goes through the shared cross product unit
// (four sign tests, pipelined through its product registers), then events
// are handed out, one line per cycle, slower if the sink stalls. A first
// sighting ends with the memory read. An end of frame sweeps the history
// memory read-modify-write. Events come out in line order; the last result
// of a beat carries o_last. One result waits in the output register while
// the next beat may be accepted. Counters are 32 bits and wrap.
module tripwire_line_crossing_counter #(
    parameter int NUM_LINES  = 4,
    parameter int NUM_TRACKS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_track_id,
    input  logic [15:0] i_box_left,
    input  logic [15:0] i_box_right,
    input  logic [15:0] i_box_bottom,
    input  logic [7:0]  i_category,
    input  logic [1:0]  i_line_select,
    input  logic        i_all_lines,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_event,
    output logic [1:0]  o_line_index,
    output logic [7:0]  o_event_track,
    output logic [7:0]  o_event_category,
    output logic        o_direction,
    output logic [31:0] o_in_count,
    output logic [31:0] o_out_count,
    output logic        o_last
);

    localparam int CW  = COORD_BITS;
    localparam int TW  = $clog2(NUM_TRACKS);
    localparam int EW  = 2 * CW + 3;
    localparam int LN  = (NUM_LINES < tlc_pkg::GEOM_SLOTS) ? NUM_LINES : tlc_pkg::GEOM_SLOTS;
    localparam int LW  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [1:0]  LAST_LINE  = 2'(LN - 1);
    localparam logic [TW:0] CNT_END    = (TW + 1)'(NUM_TRACKS);
    localparam logic [TW:0] CNT_CLR_END = (TW + 1)'(NUM_TRACKS - 1);

    // configuration registers
    logic [63:0]               r_geom [tlc_pkg::GEOM_SLOTS];
    logic [tlc_pkg::MODES_W-1:0] r_modes;
    logic                      r_enable;

    // sequencer
    tlc_pkg::t_state r_state, n_state;
    logic [TW:0]     r_cnt, n_cnt;
    logic [2:0]      r_step, n_step;
    logic [1:0]      r_line, n_line;

    // held beat
    logic [7:0]  r_id, r_cat;
    logic [1:0]  r_sel;
    logic [CW:0] r_fx, r_p1x;
    logic [CW-1:0] r_fy, r_p1y;

    // per-line results of the crossing tests
    tlc_pkg::t_sign r_sgn [3];
    logic [tlc_pkg::GEOM_SLOTS-1:0] r_emit, r_dir;

    // counts
    logic [31:0] r_inc [NUM_LINES];
    logic [31:0] r_outc [NUM_LINES];

    // output register
    logic        r_ov;
    logic        r_o_is_event, r_o_dir, r_o_last;
    logic [1:0]  r_o_line;
    logic [7:0]  r_o_track, r_o_cat;
    logic [31:0] r_o_in, r_o_out;

    // memory port
    logic          mem_we, mem_re;
    logic [TW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic in_acc, out_free, id_ok, adv, out_load, emit_bump;
    logic [63:0] w_left, w_right, w_bottom;
    logic [CW:0]   foot_x;
    logic [CW-1:0] foot_y;
    logic [63:0] g, g16, g32, g48;
    logic [CW:0] ln_ax, ln_ay, ln_bx, ln_by;
    logic [CW:0] op_px, op_py, op_ax, op_ay, op_bx, op_by;
    tlc_pkg::t_sign cr_sign;
    logic [2:0]  cur_mode;
    logic        cr_dir, cr_pass, cr_hit;
    logic [LW-1:0] cidx;
    logic [31:0] cur_in, cur_out;
    logic        sel_ok, more_after;
    logic [3:0]  emit_above;

    logic        n_o_is_event, n_o_dir, n_o_last;
    logic [1:0]  n_o_line;
    logic [7:0]  n_o_track, n_o_cat;
    logic [31:0] n_o_in, n_o_out;

    assign pready   = 1'b1;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign id_ok    = 32'(i_track_id) < NUM_TRACKS;

    // register read back
    always_comb begin
        case (paddr[5:3])
            tlc_pkg::REG_LINE0:  prdata = r_geom[0];
            tlc_pkg::REG_LINE1:  prdata = r_geom[1];
            tlc_pkg::REG_LINE2:  prdata = r_geom[2];
            tlc_pkg::REG_LINE3:  prdata = r_geom[3];
            tlc_pkg::REG_MODES:  prdata = 64'(r_modes);
            tlc_pkg::REG_ENABLE: prdata = 64'(r_enable);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tlc_pkg::GEOM_SLOTS; k++) begin
                r_geom[k] <= '0;
            end
            r_modes  <= '0;
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                tlc_pkg::REG_LINE0:  r_geom[0] <= pwdata;
                tlc_pkg::REG_LINE1:  r_geom[1] <= pwdata;
                tlc_pkg::REG_LINE2:  r_geom[2] <= pwdata;
                tlc_pkg::REG_LINE3:  r_geom[3] <= pwdata;
                tlc_pkg::REG_MODES:  r_modes <= pwdata[tlc_pkg::MODES_W-1:0];
                tlc_pkg::REG_ENABLE: r_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // foot point of the incoming box: x at doubled scale
    always_comb begin
        w_left   = 64'(i_box_left);
        w_right  = 64'(i_box_right);
        w_bottom = 64'(i_box_bottom);
        foot_x   = {1'b0, w_left[CW-1:0]} + {1'b0, w_right[CW-1:0]};
        foot_y   = w_bottom[CW-1:0];
    end

    // geometry of the line under test; line x doubled to match the foot scale
    always_comb begin
        g     = r_geom[r_line];
        g16   = g >> 16;
        g32   = g >> 32;
        g48   = g >> 48;
        ln_ax = {g[CW-1:0], 1'b0};
        ln_ay = {1'b0, g16[CW-1:0]};
        ln_bx = {g32[CW-1:0], 1'b0};
        ln_by = {1'b0, g48[CW-1:0]};
    end

    // operands of the four sign tests: old and new foot against the line,
    // then both line ends against the path
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                op_px = r_p1x;           op_py = {1'b0, r_p1y};
                op_ax = ln_ax;           op_ay = ln_ay;
                op_bx = ln_bx;           op_by = ln_by;
            end
            2'd1: begin
                op_px = r_fx;            op_py = {1'b0, r_fy};
                op_ax = ln_ax;           op_ay = ln_ay;
                op_bx = ln_bx;           op_by = ln_by;
            end
            2'd2: begin
                op_px = ln_ax;           op_py = ln_ay;
                op_ax = r_p1x;           op_ay = {1'b0, r_p1y};
                op_bx = r_fx;            op_by = {1'b0, r_fy};
            end
            default: begin
                op_px = ln_bx;           op_py = ln_by;
                op_ax = r_p1x;           op_ay = {1'b0, r_p1y};
                op_bx = r_fx;            op_by = {1'b0, r_fy};
            end
        endcase
    end

    tlc_cross #(
        .CW (CW)
    ) u_cross (
        .i_clk  (i_clk),
        .i_px   (op_px),
        .i_py   (op_py),
        .i_ax   (op_ax),
        .i_ay   (op_ay),
        .i_bx   (op_bx),
        .i_by   (op_by),
        .o_sign (cr_sign)
    );

    // crossing decision once the fourth sign is out of the unit
    always_comb begin
        cur_mode = r_modes[3 * r_line +: 3];
        cr_dir   = !r_sgn[0].pos;
        cr_pass  = (cur_mode[2:1] == tlc_pkg::FILT_BOTH)
                || (cur_mode[2:1] == tlc_pkg::FILT_A_TO_B && !cr_dir)
                || (cur_mode[2:1] == tlc_pkg::FILT_B_TO_A && cr_dir);
        cr_hit   = cur_mode[0] && cr_pass
                && ((r_sgn[0].pos && r_sgn[1].neg) || (r_sgn[0].neg && r_sgn[1].pos))
                && ((r_sgn[2].pos && cr_sign.neg) || (r_sgn[2].neg && cr_sign.pos));
    end

    tlc_hist_mem #(
        .DEPTH (NUM_TRACKS),
        .WIDTH (EW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // count lookup: one index, the read line or the line being emitted
    always_comb begin
        cidx       = (r_state == tlc_pkg::ST_REPLY) ? LW'(r_sel) : LW'(r_line);
        cur_in     = r_inc[cidx];
        cur_out    = r_outc[cidx];
        sel_ok     = 32'(r_sel) < LN;
        emit_above = r_emit >> r_line;
        more_after = (emit_above >> 1) != '0;
        adv        = !r_emit[r_line] || out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlc_pkg::ST_CLEAR: begin
                if (r_cnt == CNT_CLR_END) n_state = tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        tlc_pkg::ACT_DETECT: begin
                            if (r_enable && id_ok) n_state = tlc_pkg::ST_LOOK;
                        end
                        tlc_pkg::ACT_EOF: begin
                            if (r_enable) n_state = tlc_pkg::ST_SWEEP;
                        end
                        tlc_pkg::ACT_READ: n_state = tlc_pkg::ST_REPLY;
                        default: ;
                    endcase
                end
            end
            tlc_pkg::ST_LOOK: begin
                n_state = mem_rdata[EW-1] ? tlc_pkg::ST_CROSS : tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_CROSS: begin
                if (r_step == 3'd4 && r_line == LAST_LINE) n_state = tlc_pkg::ST_EMIT;
            end
            tlc_pkg::ST_EMIT: begin
                if (adv && r_line == LAST_LINE) n_state = tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_SWEEP: begin
                if (r_cnt == CNT_END) n_state = tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_REPLY: begin
                if (out_free) n_state = tlc_pkg::ST_IDLE;
            end
            default: n_state = tlc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready      = (r_state == tlc_pkg::ST_IDLE);
        mem_we       = 1'b0;
        mem_waddr    = r_cnt[TW-1:0];
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = TW'(i_track_id);
        n_cnt        = r_cnt;
        n_step       = r_step;
        n_line       = r_line;
        out_load     = 1'b0;
        emit_bump    = 1'b0;
        n_o_is_event = 1'b0;
        n_o_line     = r_sel;
        n_o_track    = '0;
        n_o_cat      = '0;
        n_o_dir      = 1'b0;
        n_o_in       = sel_ok ? cur_in : '0;
        n_o_out      = sel_ok ? cur_out : '0;
        n_o_last     = 1'b1;
        case (r_state)
            tlc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
            tlc_pkg::ST_IDLE: begin
                mem_re = in_acc && (i_action == tlc_pkg::ACT_DETECT) && r_enable && id_ok;
                n_cnt  = '0;
                n_step = '0;
                n_line = '0;
            end
            tlc_pkg::ST_LOOK: begin
                // record the new foot point; a first sighting ends here
                mem_we    = 1'b1;
                mem_waddr = TW'(r_id);
                mem_wdata = {1'b1, 1'b1, r_fx, r_fy};
            end
            tlc_pkg::ST_CROSS: begin
                if (r_step == 3'd4) begin
                    n_step = '0;
                    n_line = (r_line == LAST_LINE) ? 2'd0 : r_line + 2'd1;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            tlc_pkg::ST_EMIT: begin
                n_o_is_event = 1'b1;
                n_o_line     = r_line;
                n_o_track    = r_id;
                n_o_cat      = r_cat;
                n_o_dir      = r_dir[r_line];
                n_o_in       = r_dir[r_line] ? cur_in : cur_in + 32'd1;
                n_o_out      = r_dir[r_line] ? cur_out + 32'd1 : cur_out;
                n_o_last     = !more_after;
                out_load     = r_emit[r_line] && out_free;
                emit_bump    = out_load;
                if (adv) n_line = r_line + 2'd1;
            end
            tlc_pkg::ST_SWEEP: begin
                // read entry cnt, write back entry cnt-1: keep known only if seen
                mem_re    = (r_cnt != CNT_END);
                mem_raddr = r_cnt[TW-1:0];
                mem_we    = (r_cnt != '0);
                mem_waddr = TW'(r_cnt - 1'b1);
                mem_wdata = {mem_rdata[EW-1] & mem_rdata[EW-2], 1'b0, mem_rdata[EW-3:0]};
                n_cnt     = r_cnt + 1'b1;
            end
            tlc_pkg::ST_REPLY: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlc_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_step  <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_line  <= n_line;
        end
    end

    // hold the beat and the path start
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id  <= i_track_id;
            r_cat <= i_category;
            r_sel <= i_line_select;
            r_fx  <= foot_x;
            r_fy  <= foot_y;
        end
        if (r_state == tlc_pkg::ST_LOOK) begin
            r_p1x <= mem_rdata[EW-3 -: CW+1];
            r_p1y <= mem_rdata[CW-1:0];
        end
        if (r_state == tlc_pkg::ST_CROSS && r_step != 3'd0 && r_step != 3'd4) begin
            r_sgn[2'(r_step - 3'd1)] <= cr_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= '0;
            r_dir  <= '0;
        end else if (r_state == tlc_pkg::ST_LOOK) begin
            r_emit <= '0;
            r_dir  <= '0;
        end else if (r_state == tlc_pkg::ST_CROSS && r_step == 3'd4) begin
            r_emit[r_line] <= cr_hit;
            r_dir[r_line]  <= cr_dir;
        end
    end

    // counts: cleared by reset beats, bumped as events leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_inc[k]  <= '0;
                r_outc[k] <= '0;
            end
        end else if (in_acc && i_action == tlc_pkg::ACT_RESET) begin
            if (i_all_lines) begin
                for (int k = 0; k < NUM_LINES; k++) begin
                    r_inc[k]  <= '0;
                    r_outc[k] <= '0;
                end
            end else if (32'(i_line_select) < LN) begin
                r_inc[LW'(i_line_select)]  <= '0;
                r_outc[LW'(i_line_select)] <= '0;
            end
        end else if (emit_bump) begin
            r_inc[cidx]  <= n_o_in;
            r_outc[cidx] <= n_o_out;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_is_event <= n_o_is_event;
            r_o_line     <= n_o_line;
            r_o_track    <= n_o_track;
            r_o_cat      <= n_o_cat;
            r_o_dir      <= n_o_dir;
            r_o_in       <= n_o_in;
            r_o_out      <= n_o_out;
            r_o_last     <= n_o_last;
        end
    end

    assign o_valid          = r_ov;
    assign o_is_event       = r_o_is_event;
    assign o_line_index     = r_o_line;
    assign o_event_track    = r_o_track;
    assign o_event_category = r_o_cat;
    assign o_direction      = r_o_dir;
    assign o_in_count       = r_o_in;
    assign o_out_count      = r_o_out;
    assign o_last           = r_o_last;

`ifndef SYNTHESIS
    a_look_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlc_pkg::ST_LOOK) |-> ($past(r_state) == tlc_pkg::ST_IDLE))
        else $error("history lookup not preceded by an accepted beat");

    a_detect_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == tlc_pkg::ACT_DETECT && r_enable && id_ok)
        |=> (r_state == tlc_pkg::ST_LOOK))
        else $error("detection beat did not start a history lookup");

    a_sweep_no_early_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlc_pkg::ST_SWEEP && r_cnt == '0) |-> !mem_we)
        else $error("frame sweep wrote before its first read returned");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ov || i_ready))
        else $error("result loaded over a waiting result");
`endif

endmodule

### rtl/core/tlc_hist_mem.sv
// Track history memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module tlc_hist_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tlc_cross.sv
// Cross product sign unit: products registered, sign of their difference next cycle.
`timescale 1ns / 1ps

module tlc_cross #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic [CW:0]          i_px,
    input  logic [CW:0]          i_py,
    input  logic [CW:0]          i_ax,
    input  logic [CW:0]          i_ay,
    input  logic [CW:0]          i_bx,
    input  logic [CW:0]          i_by,
    output tlc_pkg::t_sign       o_sign
);

    localparam int DW = CW + 2;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx_pa, dy_pa, dx_ba, dy_ba;
    logic signed [PW-1:0] r_prod_a, r_prod_b;
    logic signed [PW:0]   diff;

    always_comb begin
        dx_pa = $signed({1'b0, i_px}) - $signed({1'b0, i_ax});
        dy_pa = $signed({1'b0, i_py}) - $signed({1'b0, i_ay});
        dx_ba = $signed({1'b0, i_bx}) - $signed({1'b0, i_ax});
        dy_ba = $signed({1'b0, i_by}) - $signed({1'b0, i_ay});
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= dx_pa * dy_ba;
        r_prod_b <= dy_pa * dx_ba;
    end

    always_comb begin
        diff       = $signed({r_prod_a[PW-1], r_prod_a}) - $signed({r_prod_b[PW-1], r_prod_b});
        o_sign.neg = diff[PW];
        o_sign.pos = !diff[PW] && (diff != '0);
    end

endmodule
